@@ hw/rtl/slmc_pkg.sv @@
// ----------------------------------------------------------------------------
// slmc_pkg
// Shared types and constants of the strict local minimum counter: sizes of
// the line stores, field widths, configuration register indexes and the
// scan position word that travels from the scanner to the judge.
// ----------------------------------------------------------------------------
`default_nettype none

package slmc_pkg;

  // Line store depth and sample width
  localparam int unsigned MAX_COLUMNS  = 1024;
  localparam int unsigned SAMPLE_WIDTH = 32;
  localparam int unsigned MAX_ROWS     = 4096;

  // Interior flags start at this row (third row, counted from one); candidates sit one row above
  localparam int unsigned BORDER = 3;

  // Position counter widths
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS);

  // Configuration register widths and port
  localparam int unsigned ROWS_CFG_W = 13;
  localparam int unsigned COLS_CFG_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

  // Result width
  localparam int unsigned CNT_W = 22;

  // Scan position of the next word, with its end-of-row / end-of-matrix flags
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             row_end;
    logic             mat_end;
    logic             interior;
  } pos_t;

endpackage : slmc_pkg

`default_nettype wire

@@ hw/rtl/slmc_ram.sv @@
// ----------------------------------------------------------------------------
// slmc_ram
// Simple dual-port line store: one write port, one read port, read data
// registered (read-before-write on the same address).
// ----------------------------------------------------------------------------
`default_nettype none

module slmc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : slmc_ram

`default_nettype wire

@@ hw/rtl/slmc_scan.sv @@
// ----------------------------------------------------------------------------
// slmc_scan
// Raster position tracker. Holds row and column of the next word, flags
// row and matrix ends against the clamped dimensions and drives the line
// store read address one column ahead of the accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module slmc_scan (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              adv_i,
  input  wire logic [slmc_pkg::ROWS_CFG_W-1:0]   row_count_i,
  input  wire logic [slmc_pkg::COLS_CFG_W-1:0]   column_count_i,
  output      slmc_pkg::pos_t                    pos_o,
  output      logic [slmc_pkg::COL_W-1:0]        rd_addr_o
);

  import slmc_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W:0]   cols_eff;
  logic [ROW_W:0]   rows_eff;
  int unsigned      cols_int;
  int unsigned      rows_int;
  logic             row_end;
  logic             mat_end;

  // Clamp dimensions: zero acts as one, oversize acts as the maximum
  always_comb begin
    cols_int = 32'(column_count_i);
    rows_int = 32'(row_count_i);
    if (cols_int == 0) cols_int = 1;
    if (cols_int > MAX_COLUMNS) cols_int = MAX_COLUMNS;
    if (rows_int == 0) rows_int = 1;
    if (rows_int > MAX_ROWS) rows_int = MAX_ROWS;
    cols_eff = (COL_W+1)'(cols_int);
    rows_eff = (ROW_W+1)'(rows_int);
  end

  assign row_end = ({1'b0, col_q} + (COL_W+1)'(1)) >= cols_eff;
  assign mat_end = row_end && (({1'b0, row_q} + (ROW_W+1)'(1)) >= rows_eff);

  // Next position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = mat_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Read ahead: fetch the column of the word after this one
  assign rd_addr_o = col_d;

  // A column is a candidate when it is not on the border; the last column of
  // a row never is
  assign pos_o.col      = col_q;
  assign pos_o.row_end  = row_end;
  assign pos_o.mat_end  = mat_end;
  assign pos_o.interior = (32'(row_q) >= (BORDER - 1)) && (col_q != '0) && !row_end;

endmodule : slmc_scan

`default_nettype wire

@@ hw/rtl/slmc_judge.sv @@
// ----------------------------------------------------------------------------
// slmc_judge
// Cross-shaped window and counter. The candidate one row above and one column
// behind the current word is judged when the current word arrives: its right
// neighbor is the line store read of the current column.
// ----------------------------------------------------------------------------
`default_nettype none

module slmc_judge (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  adv_i,
  input  wire slmc_pkg::pos_t                        pos_i,
  input  wire logic signed [slmc_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic signed [slmc_pkg::SAMPLE_WIDTH-1:0] mid_rd_i,
  input  wire logic signed [slmc_pkg::SAMPLE_WIDTH-1:0] up_rd_i,
  output      logic [slmc_pkg::CNT_W-1:0]            count_o
);

  import slmc_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] cen_q, left_q, up_q, dn_q;
  logic                           elig_q;
  logic [CNT_W-1:0]               count_q, count_d;
  logic                           hit;

  // Window around the candidate
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cen_q  <= mid_rd_i;
      left_q <= cen_q;
      up_q   <= up_rd_i;
      dn_q   <= sample_i;
    end
  end

  // Strictly below all four neighbors
  assign hit = elig_q && (cen_q < up_q) && (cen_q < dn_q) &&
               (cen_q < left_q) && (cen_q < mid_rd_i);

  assign count_d = count_q + CNT_W'(hit);
  assign count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elig_q  <= 1'b0;
      count_q <= '0;
    end else if (adv_i) begin
      elig_q  <= pos_i.interior;
      count_q <= pos_i.mat_end ? '0 : count_d;
    end
  end

endmodule : slmc_judge

`default_nettype wire

@@ hw/rtl/strict_local_minimum_counter.sv @@
// ----------------------------------------------------------------------------
// strict_local_minimum_counter
// Counts interior matrix elements strictly smaller than their up, down,
// left and right neighbors, for a matrix streamed in raster order.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------
//   in      | in        | in_valid_i / in_stall_o   | sample_i
//   out     | out       | out_valid_o / out_stall_i | minima_count_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle while not stalled, from the first cycle after reset; the
// line stores are read one column ahead so each word finds its column ready.
// A count word appears the cycle after the last word of a matrix.
// Reset clears position, count and flags and sets both dimensions to three;
// the line stores need no clearing. in_stall_o rises only when a count word
// is held and the next word would finish another matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_local_minimum_counter (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     in_valid_i,
  output      logic                                     in_stall_o,
  input  wire logic signed [slmc_pkg::SAMPLE_WIDTH-1:0] sample_i,
  output      logic                                     out_valid_o,
  input  wire logic                                     out_stall_i,
  output      logic [slmc_pkg::CNT_W-1:0]               minima_count_o,
  input  wire logic                                     cfg_valid_i,
  output      logic                                     cfg_ready_o,
  input  wire logic [slmc_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [slmc_pkg::CFG_DATA_W-1:0]          cfg_data_i
);

  import slmc_pkg::*;

  logic [ROWS_CFG_W-1:0]          row_count_q;
  logic [COLS_CFG_W-1:0]          column_count_q;
  pos_t                           pos;
  logic [COL_W-1:0]               rd_addr;
  logic                           adv;
  logic [SAMPLE_WIDTH-1:0]        mid_ram_q, up_ram_q;
  logic signed [SAMPLE_WIDTH-1:0] mid_rd, up_rd;
  logic                           byp_q;
  logic [SAMPLE_WIDTH-1:0]        byp_mid_q, byp_up_q;
  logic [CNT_W-1:0]               count;
  logic                           out_valid_q;
  logic [CNT_W-1:0]               out_count_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ROWS_CFG_W'(3);
      column_count_q <= COLS_CFG_W'(3);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT:    row_count_q    <= cfg_data_i[ROWS_CFG_W-1:0];
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i[COLS_CFG_W-1:0];
      endcase
    end
  end

  // Input handshake: hold off only a word that would need the busy result slot
  assign in_stall_o = out_valid_q && out_stall_i && pos.mat_end;
  assign adv        = in_valid_i && !in_stall_o;

  slmc_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .row_count_i    (row_count_q),
    .column_count_i (column_count_q),
    .pos_o          (pos),
    .rd_addr_o      (rd_addr)
  );

  // Line stores: the column moves down, upper gets the old middle word
  slmc_ram #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (SAMPLE_WIDTH)
  ) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (pos.col),
    .wdata_i (sample_i),
    .raddr_i (rd_addr),
    .rdata_o (mid_ram_q)
  );

  slmc_ram #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (SAMPLE_WIDTH)
  ) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (pos.col),
    .wdata_i (mid_rd),
    .raddr_i (rd_addr),
    .rdata_o (up_ram_q)
  );

  // Forward the write when a one-column row reads back what it just wrote
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= adv && (rd_addr == pos.col);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_mid_q <= sample_i;
    byp_up_q  <= mid_rd;
  end

  assign mid_rd = byp_q ? byp_mid_q : mid_ram_q;
  assign up_rd  = byp_q ? byp_up_q  : up_ram_q;

  slmc_judge u_judge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .pos_i    (pos),
    .sample_i (sample_i),
    .mid_rd_i (mid_rd),
    .up_rd_i  (up_rd),
    .count_o  (count)
  );

  // Result register: loads on the last word, frees when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && pos.mat_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && pos.mat_end) begin
      out_count_q <= count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign minima_count_o = out_count_q;

endmodule : strict_local_minimum_counter

`default_nettype wire
